FILE: hw/rtl/dfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfa_pkg;

   // Table sizes
   localparam int DFA_MAX_RULES  = 64;
   localparam int DFA_MAX_ACCEPT = 16;

   // Item kinds
   localparam logic [1:0] KIND_RULE   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_SYMBOL = 2'd2;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] from_state;
      logic [7:0] symbol;
      logic [7:0] to_state;
      logic       word_start;
   } req_type;

   typedef struct packed {
      logic [7:0] new_state;
      logic       accepted;
      logic       status;
   } rsp_type;

   // One transition rule as stored in the rule memory
   typedef struct packed {
      logic [7:0] src;
      logic [7:0] sym;
      logic [7:0] dst;
   } rule_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module dfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dfa_rule_table_recognizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Programmable table-driven automaton. Each item is taken when start is high and busy is low,
// and produces exactly one result, shown on rsp_data for a single cycle while rsp_valid is
// high; the receiver cannot stall, so it must capture the result in that cycle. A rule load
// (kind 0) appends a transition to the rule memory, a mark load (kind 1) adds an accepting
// state unless already present, and a symbol item (kind 2) steps the current state through
// the first matching rule in load order, restarting at state 0 when word_start is set. Loads
// into a full table are dropped and reported with status 1. Timing is set by two sequential
// scans over single-port-read memories, one entry per cycle: a symbol item scans the rule
// memory up to the first match and every item then scans the accepting-state memory in
// full. busy stays high through both scans; rsp_valid rises in the same cycle that busy
// falls, so the next item can be taken while the previous result is shown.
// No clearing pass after reset.
module dfa_rule_table_recognizer #(
   parameter int MAX_RULES  = dfa_pkg::DFA_MAX_RULES,
   parameter int MAX_ACCEPT = dfa_pkg::DFA_MAX_ACCEPT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dfa_pkg::req_type req_data,
   output logic                  rsp_valid,
   output dfa_pkg::rsp_type      rsp_data
);

   // Counters hold 0..MAX; addresses index 0..MAX-1
   localparam int RC_W = $clog2(MAX_RULES + 1);
   localparam int AC_W = $clog2(MAX_ACCEPT + 1);
   localparam int RA_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int AA_W = (MAX_ACCEPT > 1) ? $clog2(MAX_ACCEPT) : 1;
   localparam int RULE_W = $bits(dfa_pkg::rule_type);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,   // wait for an item
      ST_RULE = 3'b010,   // scan rules for the first match
      ST_ACC  = 3'b100    // scan accepting set, then report
   } state_type;

   state_type         state_ff, state_in;
   dfa_pkg::req_type  req_ff, req_in;
   dfa_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        cur_ff, cur_in;
   logic [RC_W-1:0]   rule_cnt_ff, rule_cnt_in;
   logic [AC_W-1:0]   acc_cnt_ff, acc_cnt_in;
   logic [RC_W-1:0]   ridx_ff, ridx_in;
   logic [AC_W-1:0]   aidx_ff, aidx_in;
   logic              pend_ff, pend_in;
   logic              hit_cur_ff, hit_cur_in;
   logic              hit_mark_ff, hit_mark_in;
   logic              err_ff, err_in;

   // Memory ports
   logic              rule_we;
   dfa_pkg::rule_type rule_wdata;
   dfa_pkg::rule_type rule_rd;
   logic [RULE_W-1:0] rule_rd_bits;
   logic              acc_we;
   logic [7:0]        acc_rd;

   // Scan helpers
   logic              rule_match;
   logic              hit_cur_w;
   logic              hit_mark_w;
   logic              rule_room;
   logic              acc_room;
   logic              mark_new;
   logic              fin_accepted;
   logic              fin_status;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rule_wdata = '{src: req_data.from_state, sym: req_data.symbol,
                         dst: req_data.to_state};
   assign rule_rd    = dfa_pkg::rule_type'(rule_rd_bits);

   assign rule_room  = (rule_cnt_ff < RC_W'(MAX_RULES));
   assign acc_room   = (acc_cnt_ff < AC_W'(MAX_ACCEPT));

   // Compare the entry read last cycle; fold it into the running hits
   assign rule_match = pend_ff && (rule_rd.src == cur_ff) && (rule_rd.sym == req_ff.symbol);
   assign hit_cur_w  = hit_cur_ff  || (pend_ff && (acc_rd == cur_ff));
   assign hit_mark_w = hit_mark_ff || (pend_ff && (acc_rd == req_ff.from_state));

   // Final accept decision: a new mark joins the set if there is room
   assign mark_new     = (req_ff.kind == dfa_pkg::KIND_ACCEPT) && !hit_mark_w;
   assign fin_accepted = hit_cur_w || (mark_new && acc_room && (req_ff.from_state == cur_ff));
   assign fin_status   = (err_ff || (mark_new && !acc_room)) ? dfa_pkg::STATUS_FULL
                                                            : dfa_pkg::STATUS_OK;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      cur_in       = cur_ff;
      rule_cnt_in  = rule_cnt_ff;
      acc_cnt_in   = acc_cnt_ff;
      ridx_in      = ridx_ff;
      aidx_in      = aidx_ff;
      pend_in      = 1'b0;
      hit_cur_in   = hit_cur_ff;
      hit_mark_in  = hit_mark_ff;
      err_in       = err_ff;
      rule_we      = 1'b0;
      acc_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               ridx_in     = '0;
               aidx_in     = '0;
               hit_cur_in  = 1'b0;
               hit_mark_in = 1'b0;
               err_in      = dfa_pkg::STATUS_OK;
               priority if (req_data.kind == dfa_pkg::KIND_RULE) begin
                  // Append at the fill point, or drop when full
                  if (rule_room) begin
                     rule_we     = 1'b1;
                     rule_cnt_in = rule_cnt_ff + 1'b1;
                  end else begin
                     err_in = dfa_pkg::STATUS_FULL;
                  end
                  state_in = ST_ACC;
               end else if (req_data.kind == dfa_pkg::KIND_SYMBOL) begin
                  if (req_data.word_start) begin
                     cur_in = '0;
                  end
                  state_in = ST_RULE;
               end else begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_RULE: begin
            priority if (rule_match) begin
               // First match in load order wins
               cur_in   = rule_rd.dst;
               state_in = ST_ACC;
            end else if (ridx_ff < rule_cnt_ff) begin
               pend_in = 1'b1;
               ridx_in = ridx_ff + 1'b1;
            end else begin
               // No rule matched: hold the state
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            hit_cur_in  = hit_cur_w;
            hit_mark_in = hit_mark_w;
            if (aidx_ff < acc_cnt_ff) begin
               pend_in = 1'b1;
               aidx_in = aidx_ff + 1'b1;
            end else begin
               if (mark_new && acc_room) begin
                  acc_we     = 1'b1;
                  acc_cnt_in = acc_cnt_ff + 1'b1;
               end
               rsp_in       = '{new_state: cur_ff, accepted: fin_accepted, status: fin_status};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         rule_cnt_ff  <= '0;
         acc_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         rule_cnt_ff  <= rule_cnt_in;
         acc_cnt_ff   <= acc_cnt_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      ridx_ff     <= ridx_in;
      aidx_ff     <= aidx_in;
      hit_cur_ff  <= hit_cur_in;
      hit_mark_ff <= hit_mark_in;
      err_ff      <= err_in;
   end

   // Rule memory: written at the fill point, read by the scan index
   dfa_ram #(
      .WIDTH (RULE_W),
      .DEPTH (MAX_RULES)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (rule_cnt_ff[RA_W-1:0]),
      .wr_data (RULE_W'(rule_wdata)),
      .rd_addr (ridx_ff[RA_W-1:0]),
      .rd_data (rule_rd_bits)
   );

   // Accepting-state memory
   dfa_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ACCEPT)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_cnt_ff[AA_W-1:0]),
      .wr_data (req_ff.from_state),
      .rd_addr (aidx_ff[AA_W-1:0]),
      .rd_data (acc_rd)
   );

   // Every item raises busy in the cycle after it is taken
   a_take_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken without going busy");

   // A result comes only out of the accept scan
   a_rsp_from_scan : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_ACC))
      else $error("result strobe without a finished scan");

   // The rule count moves only on a taken rule load
   a_rule_cnt_step : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (rule_cnt_ff != $past(rule_cnt_ff))) |->
      $past(start && !busy && (req_data.kind == dfa_pkg::KIND_RULE)))
      else $error("rule count changed without a rule load");

   // A read in flight belongs to one of the scans
   a_pend_in_scan : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((state_ff == ST_RULE) || (state_ff == ST_ACC)))
      else $error("memory read pending outside a scan");

endmodule

`default_nettype wire
